[src/tasmr_pkg.sv]
// Shared constants, register indexes and control/status types of the axis reduction block.
`timescale 1ns / 1ps
package tasmr_pkg;

    localparam int MAX_INNER  = 256;
    localparam int SLOT_W     = $clog2(MAX_INNER);
    localparam int INNER_W    = 9;
    localparam int COUNT_W    = 16;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = ACC_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE     = 2'd3;

    typedef struct packed {
        logic               elem_load;
        logic [SLOT_W-1:0]  rd_slot;
        logic               acc_en;
        logic               first;
        logic               div_start;
        logic               div_step;
        logic               load_out;
        logic               mean_mode;
        logic               final_flag;
        logic [COUNT_W-1:0] divisor;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

[src/tensor_axis_sum_mean_reduce_top.sv]
// Top level of the tensor axis sum/mean reduction block.
// The block reduces a tensor along one axis. Software writes outer_count,
// reduce_length and inner_count (a zero count acts as one, inner_count is capped
// at 256) and mean_mode; every configuration write restarts the tensor position.
// Elements stream in row-major order as signed Q16.16 words. Each word lands in
// the accumulator slot of its inner index; the first reduce row overwrites the
// slot and later rows add into it with a 48-bit exact sum. On the last reduce row
// each finished slot leaves as one result word, in row-major order of the reduced
// tensor, with final_result marking the last word of the tensor. Sum mode clips
// to 32 bits and raises saturated; mean mode divides by the reduce length,
// truncating toward zero. Timing: one word is worked on at a time. A word that
// produces no result is accepted, then its slot gets a read-modify-write in
// the accumulator RAM, whose read data is registered. A word on the last
// reduce row then goes on to the output register in sum mode; in mean mode it
// first passes the bit-serial divider, which retires one of 48 quotient bits
// per cycle. A result that waits in the output register does not block the next
// input word, only the next result. There is no clearing pass after reset.
`timescale 1ns / 1ps
module tensor_axis_sum_mean_reduce_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tasmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tasmr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [tasmr_pkg::DATA_W-1:0] i_element_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tasmr_pkg::DATA_W-1:0] o_reduced_value,
    output logic                                o_saturated,
    output logic                                o_final_result
);
    import tasmr_pkg::*;

    // Commands flow from the controller to the datapath; the datapath reports
    // only whether its output register can take a new result word.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tasmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tasmr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_element_value (i_element_value),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reduced_value (o_reduced_value),
        .o_saturated     (o_saturated),
        .o_final_result  (o_final_result)
    );

endmodule

[src/tasmr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tasmr_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/tasmr_ctrl.sv]
// Controller: configuration registers, tensor position counters and the sequencing state machine.
`timescale 1ns / 1ps
module tasmr_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cfg_we,
    input  logic [tasmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tasmr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  tasmr_pkg::t_dp_status               i_status,
    output tasmr_pkg::t_dp_cmd                  o_cmd
);
    import tasmr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [COUNT_W-1:0] r_outer_count;
    logic [COUNT_W-1:0] r_reduce_length;
    logic [INNER_W-1:0] r_inner_count;
    logic               r_mean_mode;

    logic [SLOT_W-1:0]  r_ipos;
    logic [COUNT_W-1:0] r_rpos;
    logic [COUNT_W-1:0] r_opos;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [STEP_W-1:0]  r_step;
    logic               r_first;
    logic               r_last;
    logic               r_final;

    logic [COUNT_W-1:0] w_n_outer;
    logic [COUNT_W-1:0] w_n_red;
    logic [INNER_W-1:0] w_n_inner;
    logic               w_last_in;
    logic               w_last_red;
    logic               w_last_out;
    logic               w_accept;

    // A count of zero acts as one; the inner count is capped at the slot count.
    always_comb begin
        w_n_outer = (r_outer_count == '0) ? COUNT_W'(1) : r_outer_count;
        w_n_red   = (r_reduce_length == '0) ? COUNT_W'(1) : r_reduce_length;
        if (r_inner_count == '0) begin
            w_n_inner = INNER_W'(1);
        end else if (r_inner_count > INNER_W'(MAX_INNER)) begin
            w_n_inner = INNER_W'(MAX_INNER);
        end else begin
            w_n_inner = r_inner_count;
        end
    end

    assign w_last_in  = ({1'b0, r_ipos} == (w_n_inner - INNER_W'(1)));
    assign w_last_red = (r_rpos == (w_n_red - COUNT_W'(1)));
    assign w_last_out = (r_opos == (w_n_outer - COUNT_W'(1)));
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_count   <= COUNT_W'(1);
            r_reduce_length <= COUNT_W'(1);
            r_inner_count   <= INNER_W'(1);
            r_mean_mode     <= 1'b0;
            r_ipos          <= '0;
            r_rpos          <= '0;
            r_opos          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OUTER_COUNT:   r_outer_count   <= i_cfg_data;
                REG_REDUCE_LENGTH: r_reduce_length <= i_cfg_data;
                REG_INNER_COUNT:   r_inner_count   <= i_cfg_data[INNER_W-1:0];
                REG_MEAN_MODE:     r_mean_mode     <= i_cfg_data[0];
            endcase
            r_ipos <= '0;
            r_rpos <= '0;
            r_opos <= '0;
        end else if (w_accept) begin
            if (w_last_in) begin
                r_ipos <= '0;
                if (w_last_red) begin
                    r_rpos <= '0;
                    r_opos <= w_last_out ? '0 : r_opos + COUNT_W'(1);
                end else begin
                    r_rpos <= r_rpos + COUNT_W'(1);
                end
            end else begin
                r_ipos <= r_ipos + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= (r_rpos == '0);
            r_last  <= w_last_red;
            r_final <= w_last_out && w_last_in;
        end
        if (r_state == S_DINIT) begin
            r_step <= '0;
        end else if (r_state == S_DIV) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_mean_mode) begin
                    n_state = S_DINIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.elem_load  = w_accept;
        o_cmd.rd_slot    = r_ipos;
        o_cmd.acc_en     = (r_state == S_ACC);
        o_cmd.first      = r_first;
        o_cmd.div_start  = (r_state == S_DINIT);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.load_out   = (r_state == S_OUT) && i_status.out_free;
        o_cmd.mean_mode  = r_mean_mode;
        o_cmd.final_flag = r_final;
        o_cmd.divisor    = w_n_red;
    end

endmodule

[src/tasmr_dp.sv]
// Datapath: accumulator memory, 48-bit accumulate, bit-serial mean divider and output register.
`timescale 1ns / 1ps
module tasmr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [tasmr_pkg::DATA_W-1:0] i_element_value,
    input  tasmr_pkg::t_dp_cmd                  i_cmd,
    output tasmr_pkg::t_dp_status               o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tasmr_pkg::DATA_W-1:0] o_reduced_value,
    output logic                                o_saturated,
    output logic                                o_final_result
);
    import tasmr_pkg::*;

    logic signed [DATA_W-1:0] r_elem;
    logic [SLOT_W-1:0]        r_slot;
    logic signed [ACC_W-1:0]  r_sum;
    logic [ACC_W-1:0]         r_quo;
    logic [COUNT_W-1:0]       r_rem;
    logic                     r_neg;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_sat;
    logic                     r_out_final;

    logic [ACC_W-1:0]         w_rdata;
    logic signed [ACC_W-1:0]  w_elem_ext;
    logic signed [ACC_W-1:0]  w_sum;
    logic [COUNT_W:0]         w_trial;
    logic [COUNT_W+1:0]       w_diff;
    logic                     w_fits;
    logic [DATA_W-1:0]        w_mean;
    logic                     w_ovf_pos;
    logic                     w_ovf_neg;

    tasmr_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_INNER)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc_en),
        .i_waddr (r_slot),
        .i_wdata (w_sum),
        .i_re    (i_cmd.elem_load),
        .i_raddr (i_cmd.rd_slot),
        .o_rdata (w_rdata)
    );

    assign w_elem_ext = ACC_W'(r_elem);
    assign w_sum      = i_cmd.first ? w_elem_ext : $signed(w_rdata) + w_elem_ext;

    // One quotient bit per step; the remainder always stays below the divisor.
    assign w_trial = {r_rem, r_quo[ACC_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_cmd.divisor};
    assign w_fits  = !w_diff[COUNT_W+1];

    assign w_mean    = r_neg ? (DATA_W'(0) - r_quo[DATA_W-1:0]) : r_quo[DATA_W-1:0];
    assign w_ovf_pos = !r_sum[ACC_W-1] && (|r_sum[ACC_W-2:DATA_W-1]);
    assign w_ovf_neg = r_sum[ACC_W-1] && !(&r_sum[ACC_W-2:DATA_W-1]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.elem_load) begin
            r_elem <= i_element_value;
            r_slot <= i_cmd.rd_slot;
        end
        if (i_cmd.acc_en) begin
            r_sum <= w_sum;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_sum[ACC_W-1];
            r_quo <= r_sum[ACC_W-1] ? (ACC_W'(0) - r_sum) : r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[ACC_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_final <= i_cmd.final_flag;
            if (i_cmd.mean_mode) begin
                r_out_value <= w_mean;
                r_out_sat   <= 1'b0;
            end else if (w_ovf_pos) begin
                r_out_value <= {1'b0, {(DATA_W-1){1'b1}}};
                r_out_sat   <= 1'b1;
            end else if (w_ovf_neg) begin
                r_out_value <= {1'b1, {(DATA_W-1){1'b0}}};
                r_out_sat   <= 1'b1;
            end else begin
                r_out_value <= r_sum[DATA_W-1:0];
                r_out_sat   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_reduced_value   = r_out_value;
    assign o_saturated       = r_out_sat;
    assign o_final_result    = r_out_final;

endmodule

[src/tasmr_checker.sv]
// Port-level checker for the axis reduction block and its bind to the top level.
`timescale 1ns / 1ps
module tasmr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_reduced_value,
    input logic        o_saturated
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A clipped sum is always one of the two 32-bit limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_reduced_value == 32'h7fffffff || o_reduced_value == 32'h80000000))
        else $error("saturated result is not a range limit");

    // Every accepted word makes the block stall its input before it takes another word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    // A new result word only appears while the block was busy with an input word.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word appeared without work in progress");

endmodule

bind tensor_axis_sum_mean_reduce_top tasmr_checker u_checker (.*);

[dv/tensor_axis_sum_mean_reduce_top_tb.sv]
// Self-checking testbench of the axis sum/mean reduction block: directed table, then random tensors.
`timescale 1ns / 1ps
module tensor_axis_sum_mean_reduce_top_tb;
    import tasmr_pkg::*;

    // Stop offering words once this many have gone in.
    localparam int WORD_BUDGET = 1550;
    // Guard wait that covers any word still in flight, a mean result included.
    localparam int LATENCY_GUARD = 64;
    localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN = -64'sh0000_0000_8000_0000;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
        '{REG_OUTER_COUNT, REG_REDUCE_LENGTH, REG_INNER_COUNT, REG_MEAN_MODE};

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              saturated;
        logic              final_result;
    } line_result_t;

    // One row of the directed table: a register write or one element word.
    // Where typed is set, result holds the expected result of that word.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [DATA_W-1:0]     word;
        logic                  typed;
        line_result_t          result;
    } stim_row_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic signed [DATA_W-1:0]     i_element_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [DATA_W-1:0]     o_reduced_value;
    logic                         o_saturated;
    logic                         o_final_result;

    // Shadow of the block: its registers, its accumulator slots and its position in the tensor.
    logic [COUNT_W-1:0] red_outer;
    logic [COUNT_W-1:0] red_reduce;
    logic [INNER_W-1:0] red_inner;
    logic               red_mean;
    longint             line_acc [MAX_INNER];
    int                 pos_inner;
    int                 pos_reduce;
    int                 pos_outer;

    line_result_t expected_lines [$];
    int           bad_results;
    int           words_sent;
    int           send_mode;
    int           recv_mode;
    int           hold_len;
    // Travel with each word so that the checker knows which words carry a typed expectation.
    logic         drv_typed;
    line_result_t drv_expect;

    tensor_axis_sum_mean_reduce_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reduced_value (o_reduced_value),
        .o_saturated     (o_saturated),
        .o_final_result  (o_final_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A zero count acts as one; a count above the cap acts as the cap.
    function automatic int eff_count(input int c, input int cap);
        if (c == 0) return 1;
        if (c > cap) return cap;
        return c;
    endfunction

    // Folds one element into its slot and advances the position. Returns 1 when the word
    // finishes a slot, with the finished line in r.
    function automatic logic reduce_element(input logic signed [DATA_W-1:0] v,
                                            output line_result_t r);
        int     n_out;
        int     n_red;
        int     n_in;
        longint s;
        logic   done;
        n_out = eff_count(red_outer, 65535);
        n_red = eff_count(red_reduce, 65535);
        n_in  = eff_count(red_inner, MAX_INNER);
        r     = '0;
        done  = 1'b0;
        if (pos_reduce == 0)
            line_acc[pos_inner] = v;
        else
            line_acc[pos_inner] += v;
        if (pos_reduce == n_red - 1) begin
            s = line_acc[pos_inner];
            if (red_mean) begin
                r.value = DATA_W'(s / longint'(n_red));
            end else if (s > Q_MAX) begin
                r.value     = DATA_W'(Q_MAX);
                r.saturated = 1'b1;
            end else if (s < Q_MIN) begin
                r.value     = DATA_W'(Q_MIN);
                r.saturated = 1'b1;
            end else begin
                r.value = DATA_W'(s);
            end
            r.final_result = (pos_outer == n_out - 1) && (pos_inner == n_in - 1);
            done = 1'b1;
        end
        pos_inner++;
        if (pos_inner >= n_in) begin
            pos_inner = 0;
            pos_reduce++;
            if (pos_reduce >= n_red) begin
                pos_reduce = 0;
                pos_outer++;
                if (pos_outer >= n_out) pos_outer = 0;
            end
        end
        return done;
    endfunction

    // Tracks every write, every accepted word and every accepted result at the clock edge.
    always @(posedge i_clk) begin
        line_result_t got;
        line_result_t want;
        if (!i_rst_n) begin
            red_outer  = 1;
            red_reduce = 1;
            red_inner  = 1;
            red_mean   = 1'b0;
            foreach (line_acc[i]) line_acc[i] = 0;
            pos_inner  = 0;
            pos_reduce = 0;
            pos_outer  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OUTER_COUNT:   red_outer  = i_cfg_data;
                    REG_REDUCE_LENGTH: red_reduce = i_cfg_data;
                    REG_INNER_COUNT:   red_inner  = i_cfg_data[INNER_W-1:0];
                    REG_MEAN_MODE:     red_mean   = i_cfg_data[0];
                    default: ;
                endcase
                // Any write restarts the tensor.
                pos_inner  = 0;
                pos_reduce = 0;
                pos_outer  = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                if (reduce_element(i_element_value, want))
                    expected_lines.insert(expected_lines.size(),
                                          drv_typed ? drv_expect : want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_reduced_value, o_saturated, o_final_result};
                if (expected_lines.size() == 0) begin
                    if (bad_results < 10)
                        $display("unexpected result: value %h saturated %b final %b",
                                 got.value, got.saturated, got.final_result);
                    bad_results++;
                end else begin
                    want = expected_lines.pop_front();
                    if (got !== want) begin
                        if (bad_results < 10)
                            $display("mismatch: expected value %h saturated %b final %b, %s %h %b %b",
                                     want.value, want.saturated, want.final_result, "got",
                                     got.value, got.saturated, got.final_result);
                        bad_results++;
                    end
                end
            end
        end
    end

    // Mode 0 never idles, mode 1 draws a random idle gap every time, mode 2 idles only now and then.
    function automatic int draw_idle(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 7);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_element();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return DATA_W'($urandom_range(0, 511)) - 32'd256;
            3:       return $urandom >> $urandom_range(1, 30);
            4:       return ~($urandom >> $urandom_range(1, 30));
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        reg_row           = '0;
        reg_row.is_reg    = 1'b1;
        reg_row.reg_index = idx;
        reg_row.reg_data  = data;
    endfunction

    function automatic stim_row_t word_row(input logic [DATA_W-1:0] w);
        word_row      = '0;
        word_row.word = w;
    endfunction

    function automatic stim_row_t checked_row(input logic [DATA_W-1:0] w,
                                              input logic [DATA_W-1:0] value,
                                              input logic sat, input logic fin);
        checked_row        = '0;
        checked_row.word   = w;
        checked_row.typed  = 1'b1;
        checked_row.result = '{value, sat, fin};
    endfunction

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(input logic [DATA_W-1:0] w, input logic typed,
                             input line_result_t r);
        int gap;
        gap = draw_idle(send_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= w;
        drv_typed       <= typed;
        drv_expect      <= r;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Stops sending and waits until every expected result is out and the last word is done.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (LATENCY_GUARD) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Result side: a random stall before each result, or a long hold when one is requested.
    initial begin
        int k;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else begin
                k = draw_idle(recv_mode);
                if (k > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (k) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        stim_row_t          directed [$];
        logic [CFG_DATA_W-1:0] vals [4];
        logic [3:0]         mask;
        int                 cur_outer;
        int                 cur_reduce;
        int                 cur_inner;
        int                 phase;
        int                 n_words;
        int                 tensor_words;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_OUTER_COUNT;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_element_value = '0;
        drv_typed       = 1'b0;
        drv_expect      = '0;
        bad_results     = 0;
        words_sent      = 0;
        send_mode       = 1;
        recv_mode       = 1;
        hold_len        = 0;
        cur_outer       = 1;
        cur_reduce      = 1;
        cur_inner       = 1;

        directed = '{
            // Reset counts are all one: every word is a whole tensor and its own final result.
            checked_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1),
            checked_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1),
            checked_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1),
            checked_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1),
            // Sum of two: clipping at both ends, then a sum that cancels.
            reg_row(REG_REDUCE_LENGTH, 16'd2),
            word_row(32'h7FFF_FFFF),
            checked_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1),
            word_row(32'h8000_0000),
            checked_row(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1),
            word_row(32'hFFFF_FFFF),
            checked_row(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1),
            // Mean of two: extremes stay exact, and minus three halves truncates to minus one.
            reg_row(REG_MEAN_MODE, 16'd1),
            word_row(32'h7FFF_FFFF),
            checked_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1),
            word_row(32'hFFFF_FFFD),
            checked_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1),
            word_row(32'h8000_0000),
            checked_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1),
            // Zero in every count acts as one.
            reg_row(REG_OUTER_COUNT, 16'd0),
            reg_row(REG_REDUCE_LENGTH, 16'd0),
            reg_row(REG_INNER_COUNT, 16'd0),
            reg_row(REG_MEAN_MODE, 16'd0),
            checked_row(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1),
            // Two inner slots over two rows, then a write in the middle drops the tensor.
            reg_row(REG_INNER_COUNT, 16'd2),
            reg_row(REG_REDUCE_LENGTH, 16'd2),
            word_row(32'h0001_0000),
            word_row(32'h0002_0000),
            word_row(32'h0003_0000),
            reg_row(REG_OUTER_COUNT, 16'd2),
            word_row(32'h0000_0001),
            word_row(32'h0000_0002),
            word_row(32'h0000_0003),
            word_row(32'h0000_0004)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            if (directed[n].is_reg) begin
                settle_block();
                write_reg(directed[n].reg_index, directed[n].reg_data);
                i_cfg_we <= 1'b0;
            end else begin
                send_word(directed[n].word, directed[n].typed, directed[n].result);
            end
        end

        // The first few phases cover the capped inner count, the largest counts and the
        // long hold on the result side; the rest are small tensors of random shape.
        phase = 0;
        while (words_sent < WORD_BUDGET) begin
            mask      = 4'hF;
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            case (phase)
                0: begin
                    vals    = '{16'd1, 16'd2, 16'h01FF, 16'd1};
                    n_words = 2 * MAX_INNER;
                end
                1: begin
                    vals    = '{16'hFFFF, 16'd1, 16'd1, 16'd0};
                    n_words = 40;
                end
                2: begin
                    // No line finishes here; only the drop on the next write is seen.
                    vals    = '{16'd1, 16'hFFFF, 16'd3, 16'd1};
                    n_words = 30;
                end
                3: begin
                    vals      = '{16'd3, 16'd1, 16'd4, 16'd0};
                    n_words   = 60;
                    send_mode = 0;
                end
                default: begin
                    mask    = 4'($urandom_range(1, 15));
                    vals[0] = CFG_DATA_W'($urandom_range(0, 4));
                    vals[1] = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(7, 40))
                                                          : CFG_DATA_W'($urandom_range(0, 6));
                    vals[2] = CFG_DATA_W'($urandom_range(0, 8));
                    vals[3] = CFG_DATA_W'($urandom_range(0, 1));
                    n_words = 0;
                end
            endcase

            settle_block();
            for (int i = 0; i < 4; i++) begin
                if (mask[i]) write_reg(REG_ORDER[i], vals[i]);
            end
            i_cfg_we <= 1'b0;
            if (mask[0]) cur_outer  = vals[0];
            if (mask[1]) cur_reduce = vals[1];
            if (mask[2]) cur_inner  = vals[2][INNER_W-1:0];

            if (n_words == 0) begin
                tensor_words = eff_count(cur_outer, 65535) * eff_count(cur_reduce, 65535)
                               * eff_count(cur_inner, MAX_INNER);
                n_words = tensor_words * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    n_words += $urandom_range(0, tensor_words - 1);
                if (n_words > 120) n_words = 120;
            end

            for (int k = 0; k < n_words; k++) begin
                if (phase == 3 && k == 10) hold_len = 300;
                if (phase == 3 && k == 40) settle_block();
                send_word(draw_element(), 1'b0, '0);
            end
            phase++;
        end

        settle_block();
        if (bad_results == 0 && expected_lines.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
